### rtl/tdr_pkg.sv
// Shared types and constants of the table-driven automaton runner.
// No dependencies; imported by tdr_out_fifo and table_driven_dfa_runner_unit.
package tdr_pkg;

  typedef enum logic [2:0] {
    ACT_WR_MAP   = 3'd0,
    ACT_WR_TRANS = 3'd1,
    ACT_WR_TAG   = 3'd2,
    ACT_RESTART  = 3'd3,
    ACT_STEP     = 3'd4,
    ACT_LOOK     = 3'd5
  } action_e;

  // Configuration register indexes.
  localparam logic CFG_NUM_STATES  = 1'b0;
  localparam logic CFG_START_STATE = 1'b1;

  // State tags.
  localparam logic [1:0] TAG_REJECT = 2'd0;
  localparam logic [1:0] TAG_INTER  = 2'd2;

  localparam logic [6:0] NOT_STARTED    = 7'd127;
  localparam logic [6:0] NUM_STATES_RST = 7'd64;

  // Result buffer.
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  // Packed so that tag sits in the lowest bits.
  typedef struct packed {
    logic       error;
    logic       trapped;
    logic [6:0] state_now;
    logic [1:0] tag;
  } result_t;

endpackage

### rtl/tdr_out_fifo.sv
// Result buffer of the automaton runner: small flop FIFO feeding the output stream.
// Depends on tdr_pkg (result_t, depth constants).
module tdr_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  tdr_pkg::result_t               push_data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output tdr_pkg::result_t               data_o,
  output logic [tdr_pkg::OUT_CNT_W-1:0]  count_o
);
  import tdr_pkg::*;

  result_t              buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) cnt_d = cnt_q + OUT_CNT_W'(1);
    else if (!push_i && do_pop) cnt_d = cnt_q - OUT_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/table_driven_dfa_runner_unit.sv
// Top level of the table-driven automaton runner: class map, transition store and
// tag memories in a three-stage read/modify pipeline. Depends on tdr_pkg, tdr_out_fifo.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: action; tdata: operands
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: tag, state, trap, error
//  cfg       | in        | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle while the result buffer has room; m_axis_tvalid follows stage 3.
//  Stage 1 reads the class map, stage 2 the transition store, stage 3 the tag memory;
//  the next state loops from the transition read data straight into the next read
//  address, which is what bounds the rate at one symbol per cycle.
//  After reset a clearing pass writes every transition and class-map entry to empty,
//  one transition address after another; no input is taken meanwhile.
//  Input ready depends only on registers: items in flight plus buffered results must
//  leave room in the 8-entry result buffer, so output stalls never reach s_axis_tready
//  combinationally.
module table_driven_dfa_runner_unit #(
  parameter int unsigned MAX_STATES   = 64,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  // symbol[7:0], state_index[13:8], class_symbol[21:14], target_state[27:22],
  // entry_valid[28], tag_value[30:29], zero[31]
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tag[1:0], state_now[8:2], trapped[9], error[10], zero[15:11]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);
  import tdr_pkg::*;

  localparam int unsigned ST_W     = $clog2(MAX_STATES);
  localparam int unsigned CLS_W    = $clog2(SYMBOL_COUNT);
  localparam int unsigned ADDR_W   = ST_W + CLS_W;
  localparam int unsigned CM_DEPTH = 1 << CLS_W;
  localparam int unsigned TR_DEPTH = 1 << ADDR_W;
  localparam int unsigned TG_DEPTH = 1 << ST_W;

  // ---------------------------------------------------------------- input unpack
  action_e    in_act;
  logic [7:0] in_sym, in_csym;
  logic [5:0] in_sidx, in_tgt;
  logic       in_ev;
  logic [1:0] in_tval;
  logic       s_acc;

  assign in_act  = action_e'(s_axis_tuser);
  assign in_sym  = s_axis_tdata[7:0];
  assign in_sidx = s_axis_tdata[13:8];
  assign in_csym = s_axis_tdata[21:14];
  assign in_tgt  = s_axis_tdata[27:22];
  assign in_ev   = s_axis_tdata[28];
  assign in_tval = s_axis_tdata[30:29];
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- configuration
  logic [6:0] num_states_q;
  logic [5:0] start_state_q;
  logic [6:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= NUM_STATES_RST;
      start_state_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_STATES:  num_states_q  <= cfg_wdata_i;
        CFG_START_STATE: start_state_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Saturate the state count at the store size.
  assign n_eff = (32'(num_states_q) > MAX_STATES) ? 7'(MAX_STATES) : num_states_q;

  // ---------------------------------------------------------------- clearing pass
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == '1) clr_busy_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- credit / ready
  logic [OUT_CNT_W-1:0] fifo_cnt, in_flight;
  logic                 p1_v_q, p2_v_q, p3_v_q;

  assign in_flight = OUT_CNT_W'(p1_v_q) + OUT_CNT_W'(p2_v_q) + OUT_CNT_W'(p3_v_q);
  assign s_axis_tready = !clr_busy_q && ((fifo_cnt + in_flight) < OUT_CNT_W'(OUT_DEPTH));

  // ---------------------------------------------------------------- stage 1: class map
  logic [8:0] cmap_mem_q [CM_DEPTH];  // {present, class}
  logic [8:0] cm_rd_q;
  logic       in_sym_ok;

  assign in_sym_ok = (32'(in_sym) < SYMBOL_COUNT);

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cmap_mem_q[clr_addr_q[CLS_W-1:0]] <= '0;
    end else if (s_acc && in_act == ACT_WR_MAP && in_sym_ok) begin
      cmap_mem_q[CLS_W'(in_sym)] <= in_ev ? {1'b1, in_csym} : 9'd0;
    end
    cm_rd_q <= cmap_mem_q[CLS_W'(in_sym)];
  end

  action_e    p1_act_q;
  logic [7:0] p1_sym_q, p1_csym_q;
  logic [5:0] p1_sidx_q, p1_tgt_q;
  logic       p1_ev_q, p1_symok_q;
  logic [1:0] p1_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else         p1_v_q <= s_acc;
  end

  always_ff @(posedge clk_i) begin
    p1_act_q   <= in_act;
    p1_sym_q   <= in_sym;
    p1_csym_q  <= in_csym;
    p1_sidx_q  <= in_sidx;
    p1_tgt_q   <= in_tgt;
    p1_ev_q    <= in_ev;
    p1_symok_q <= in_sym_ok;
    p1_tval_q  <= in_tval;
  end

  // ---------------------------------------------------------------- stage 2: transitions
  logic [7:0] p1_cls;
  logic       p1_cls_ok, p1_wr_tr;
  logic [6:0] cur_fwd;            // state after every item up to stage 2
  logic [6:0] tr_mem_q [TR_DEPTH]; // {present, target}
  logic [6:0] tr_rd_q;

  // Unmapped symbols pass through as their own class.
  assign p1_cls    = (p1_symok_q && cm_rd_q[8]) ? cm_rd_q[7:0] : p1_sym_q;
  assign p1_cls_ok = (32'(p1_cls) < SYMBOL_COUNT);
  assign p1_wr_tr  = p1_v_q && p1_act_q == ACT_WR_TRANS
                     && (32'(p1_sidx_q) < MAX_STATES) && (32'(p1_csym_q) < SYMBOL_COUNT);

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tr_mem_q[clr_addr_q] <= '0;
    end else if (p1_wr_tr) begin
      tr_mem_q[{ST_W'(p1_sidx_q), CLS_W'(p1_csym_q)}] <= p1_ev_q ? {1'b1, p1_tgt_q} : 7'd0;
    end
    tr_rd_q <= tr_mem_q[{ST_W'(cur_fwd), CLS_W'(p1_cls)}];
  end

  action_e    p2_act_q;
  logic [6:0] p2_cur_q;
  logic       p2_clsok_q;
  logic [5:0] p2_sidx_q;
  logic [1:0] p2_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else         p2_v_q <= p1_v_q;
  end

  always_ff @(posedge clk_i) begin
    p2_act_q   <= p1_act_q;
    p2_cur_q   <= cur_fwd;
    p2_clsok_q <= p1_cls_ok;
    p2_sidx_q  <= p1_sidx_q;
    p2_tval_q  <= p1_tval_q;
  end

  // ---------------------------------------------------------------- stage 3: next state, tags
  logic       p2_is_run, p2_err, p2_trap, p2_use_tag, tag_addr_ok;
  logic [6:0] p2_nxt, tag_addr, cur_state_q;

  assign p2_is_run = (p2_act_q == ACT_STEP) || (p2_act_q == ACT_LOOK);
  assign p2_err    = (p2_cur_q >= n_eff);
  assign p2_trap   = !p2_err && (!p2_clsok_q || !tr_rd_q[6]);
  assign p2_nxt    = p2_trap ? (n_eff - 7'd1) : {1'b0, tr_rd_q[5:0]};

  // Forward the stage-2 result so the following symbol reads from the right row.
  always_comb begin
    cur_fwd = cur_state_q;
    if (p2_v_q && p2_act_q == ACT_RESTART) cur_fwd = {1'b0, start_state_q};
    else if (p2_v_q && p2_act_q == ACT_STEP && !p2_err) cur_fwd = p2_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cur_state_q <= NOT_STARTED;
    else         cur_state_q <= cur_fwd;
  end

  assign tag_addr    = (p2_act_q == ACT_RESTART) ? {1'b0, start_state_q} : p2_nxt;
  assign tag_addr_ok = (32'(tag_addr) < MAX_STATES);
  assign p2_use_tag  = tag_addr_ok && ((p2_act_q == ACT_RESTART)
                       || (p2_act_q == ACT_STEP && !p2_err)
                       || (p2_act_q == ACT_LOOK && !p2_err && !p2_trap));

  logic [1:0] tag_mem_q [TG_DEPTH];
  logic [1:0] tag_rd_q;

  always_ff @(posedge clk_i) begin
    if (p2_v_q && p2_act_q == ACT_WR_TAG && (32'(p2_sidx_q) < MAX_STATES)) begin
      tag_mem_q[ST_W'(p2_sidx_q)] <= (p2_tval_q > TAG_INTER) ? TAG_INTER : p2_tval_q;
    end
    tag_rd_q <= tag_mem_q[ST_W'(tag_addr)];
  end

  logic       p3_use_q, p3_trap_q, p3_err_q;
  logic [6:0] p3_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else         p3_v_q <= p2_v_q;
  end

  always_ff @(posedge clk_i) begin
    p3_use_q   <= p2_use_tag;
    p3_trap_q  <= p2_is_run && p2_trap;
    p3_err_q   <= p2_is_run && p2_err;
    p3_state_q <= cur_fwd;
  end

  // ---------------------------------------------------------------- result buffer
  result_t p3_res, out_res;

  assign p3_res.tag       = p3_use_q ? tag_rd_q : TAG_REJECT;
  assign p3_res.state_now = p3_state_q;
  assign p3_res.trapped   = p3_trap_q;
  assign p3_res.error     = p3_err_q;

  tdr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p3_v_q),
    .push_data_i (p3_res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = {5'd0, out_res};

  // ---------------------------------------------------------------- assertions
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt + in_flight) <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result buffer credit overrun");

  a_fwd_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> (p2_cur_q == cur_state_q))
    else $error("stage 2 start state differs from committed state");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p2_v_q && p2_is_run && p2_err) |=> (cur_state_q == $past(p2_cur_q)))
    else $error("state changed on out-of-range step");

  a_trap_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> !(p3_trap_q && p3_err_q))
    else $error("trapped and error both set");

endmodule
